### rtl/av1shl_pkg.sv
package av1shl_pkg;

   localparam int unsigned OFS_W = 25;
   localparam int unsigned START_W = 24;
   localparam int unsigned LEN_W = 25;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned RSP_USER_W = 8;

   localparam logic [OFS_W-1:0] MAX_FRAME_BYTES = 25'h100_0000;

   localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  header_start;
      logic [LEN_W-1:0]    header_length;
   } result_type;

endpackage

### rtl/av1shl_parser.sv
module av1shl_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   last_of_frame,
   output logic                   emit,
   output av1shl_pkg::result_type result
);
   import av1shl_pkg::*;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_EXT = 3'd1;
   localparam logic [2:0] PH_SIZE = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   localparam int unsigned KIND_SEQ_HEADER = 1;
   localparam logic [3:0] SIZE_BYTES_MAX = 4'd8;
   localparam logic [OFS_W-1:0] ACC_SAT = MAX_FRAME_BYTES + 25'd1;

   logic [2:0]         phase_ff, phase_in;
   logic [OFS_W-1:0]   offset_ff, offset_in;
   logic [START_W-1:0] unit_start_ff, unit_start_in;
   logic [3:0]         unit_kind_ff, unit_kind_in;
   logic [OFS_W-1:0]   acc_ff, acc_in;
   logic [3:0]         count_ff, count_in;
   logic [OFS_W-1:0]   left_ff, left_in;

   logic [5:0]         shamt;
   logic [55:0]        chunk;
   logic [OFS_W:0]     sum;
   logic [OFS_W-1:0]   acc_sat;
   logic [OFS_W:0]     reach;
   logic [OFS_W-1:0]   left_dec;
   logic               unit_end;

   always_comb begin
      shamt = {3'b000, count_ff[2:0]} * 6'd7;
      chunk = {49'd0, data_byte[6:0]} << shamt;
      sum = {1'b0, acc_ff} + {1'b0, chunk[OFS_W-1:0]};
      if ((|chunk[55:OFS_W]) || (sum > {1'b0, MAX_FRAME_BYTES})) begin
         acc_sat = ACC_SAT;
      end else begin
         acc_sat = sum[OFS_W-1:0];
      end
      reach = {1'b0, acc_sat} + {1'b0, offset_ff + 25'd1};
      left_dec = (left_ff != '0) ? left_ff - 25'd1 : left_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      offset_in = offset_ff;
      unit_start_in = unit_start_ff;
      unit_kind_in = unit_kind_ff;
      acc_in = acc_ff;
      count_in = count_ff;
      left_in = left_ff;
      unit_end = 1'b0;
      emit = 1'b0;
      result = '{status: STATUS_BAD, header_start: '0, header_length: '0};

      if (phase_ff != PH_DONE) begin
         if (offset_ff >= MAX_FRAME_BYTES) begin
            emit = 1'b1;
            phase_in = PH_DONE;
         end else begin
            offset_in = offset_ff + 25'd1;
            case (phase_ff)
               PH_HEADER: begin
                  unit_start_in = offset_ff[START_W-1:0];
                  unit_kind_in = data_byte[6:3];
                  if (data_byte[7] || data_byte[0] || !data_byte[1]) begin
                     emit = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     acc_in = '0;
                     count_in = '0;
                     phase_in = data_byte[2] ? PH_EXT : PH_SIZE;
                  end
               end
               PH_EXT: begin
                  phase_in = PH_SIZE;
               end
               PH_SIZE: begin
                  acc_in = acc_sat;
                  count_in = count_ff + 4'd1;
                  if (data_byte[7]) begin
                     if (count_in >= SIZE_BYTES_MAX) begin
                        emit = 1'b1;
                        phase_in = PH_DONE;
                     end
                  end else if (reach > {1'b0, MAX_FRAME_BYTES}) begin
                     emit = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     left_in = acc_sat;
                     if (acc_sat == '0) begin
                        unit_end = 1'b1;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
               default: begin
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     unit_end = 1'b1;
                  end
               end
            endcase
            if (unit_end) begin
               phase_in = PH_HEADER;
               if (unit_kind_ff == 4'(KIND_SEQ_HEADER)) begin
                  emit = 1'b1;
                  phase_in = PH_DONE;
                  result.status = STATUS_FOUND;
                  result.header_start = unit_start_ff;
                  result.header_length = offset_in - {1'b0, unit_start_ff};
               end
            end
         end
      end

      if (last_of_frame) begin
         if (phase_in != PH_DONE) begin
            emit = 1'b1;
            result = '{status: (phase_in == PH_HEADER) ? STATUS_NONE : STATUS_BAD,
                       header_start: '0, header_length: '0};
         end
         phase_in = PH_HEADER;
         offset_in = '0;
         unit_start_in = '0;
         unit_kind_in = '0;
         acc_in = '0;
         count_in = '0;
         left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         offset_ff <= '0;
         unit_start_ff <= '0;
         unit_kind_ff <= '0;
         acc_ff <= '0;
         count_ff <= '0;
         left_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         offset_ff <= offset_in;
         unit_start_ff <= unit_start_in;
         unit_kind_ff <= unit_kind_in;
         acc_ff <= acc_in;
         count_ff <= count_in;
         left_ff <= left_in;
      end
   end

endmodule

### rtl/av1_sequence_header_locator_core.sv
// Locates the first sequence header OBU in an AV1 frame.
// The req channel carries one frame byte per transaction, with req_tlast on the
// final byte of the frame. The rsp channel carries at most one transaction per
// frame: the status in rsp_tuser and, for a found header, its start offset and
// total length in rsp_tdata. A result is given as soon as the header's payload
// is complete or the stream is judged malformed, or else at the last byte.
// Bytes after a decision are consumed without effect until the last byte.
// Each byte is held in an input register and parsed from there; a result is
// stored in an output register that drives rsp.
// The block takes one byte every cycle while no deciding byte is held back; the
// single parse stage with its OBU state registers sets that figure. Only a byte
// that produces a result waits when the rsp side stalls and the output register
// is still full; other bytes keep flowing. Reset clears the parse state and drops
// any pending result, readying the block for the start of a new frame.
module av1_sequence_header_locator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [av1shl_pkg::REQ_DATA_W-1:0] req_tdata,  // data_byte[7:0]
   input  logic                              req_tlast,  // last_of_frame
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [av1shl_pkg::RSP_DATA_W-1:0] rsp_tdata,  // header_start[23:0], header_length[48:24]
   output logic [av1shl_pkg::RSP_USER_W-1:0] rsp_tuser   // status[1:0]
);
   import av1shl_pkg::*;

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;
   result_type result;
   logic       emit;
   logic       out_free;
   logic       step;

   assign out_free = !out_vld_ff || rsp_tready;
   assign step = in_vld_ff && (!emit || out_free);
   assign req_tready = !in_vld_ff || step;
   assign out_vld_in = (step && emit) || (out_vld_ff && !rsp_tready);

   av1shl_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (in_byte_ff),
      .last_of_frame (in_last_ff),
      .emit          (emit),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[7:0];
         in_last_ff <= req_tlast;
      end
      if (step && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {7'd0, out_ff.header_length, out_ff.header_start};
   assign rsp_tuser = {6'd0, out_ff.status};

   a_in_held: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !step |=> in_vld_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("input byte dropped while parse stalled");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |=> out_vld_ff && $stable(out_ff))
      else $error("pending result overwritten");

   a_found_len: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.status == STATUS_FOUND |-> out_ff.header_length != '0)
      else $error("found header with zero length");

   a_other_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.status != STATUS_FOUND
         |-> out_ff.header_start == '0 && out_ff.header_length == '0)
      else $error("non-found result carries offsets");

endmodule

### tb/tb_av1_sequence_header_locator_core.sv
module tb_av1_sequence_header_locator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import av1shl_pkg::*;

   localparam logic [63:0] FRAME_BOUND = 64'(MAX_FRAME_BYTES);
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 10;

   localparam logic [3:0] OBU_SEQUENCE_HEADER = 4'd1;
   localparam logic [3:0] OBU_TEMPORAL_DELIMITER = 4'd2;
   localparam logic [3:0] OBU_PADDING = 4'd15;

   localparam logic [7:0] HDR_FORBIDDEN = 8'h80;
   localparam logic [7:0] HDR_EXT = 8'h04;
   localparam logic [7:0] HDR_HAS_SIZE = 8'h02;
   localparam logic [7:0] HDR_RESERVED = 8'h01;
   localparam logic [7:0] LEB_MORE = 8'h80;
   localparam logic [7:0] LEB_VALUE = 8'h7f;
   localparam int LEB_MAX_BYTES = 8;

   typedef enum logic [2:0] {
      SEEK_HEADER,
      SEEK_EXT,
      SEEK_SIZE,
      SEEK_PAYLOAD,
      SEEK_DONE
   } parse_phase_type;

   typedef enum int {
      FLAW_NONE,
      FLAW_FORBIDDEN,
      FLAW_RESERVED,
      FLAW_NO_SIZE,
      FLAW_ENDLESS_SIZE,
      FLAW_OVERSIZE,
      FLAW_TRUNCATED
   } frame_flaw_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // data_byte[7:0]
   logic                  req_tlast;   // last_of_frame
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // header_start[23:0], header_length[48:24]
   logic [RSP_USER_W-1:0] rsp_tuser;   // status[1:0]

   av1_sequence_header_locator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   result_type      expected_results[$];
   logic [7:0]      frame_buf[$];
   int              error_count = 0;
   int              req_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              holds_requested = 0;

   parse_phase_type parse_phase;
   logic [63:0]     frame_offset;
   logic [63:0]     unit_first;
   logic [3:0]      unit_kind;
   logic [63:0]     obu_size;
   int              obu_size_bytes;
   logic [63:0]     payload_left;

   function automatic logic [7:0] obu_header(input logic [3:0] kind, input logic has_ext);
      return {1'b0, kind, has_ext, 1'b1, 1'b0};
   endfunction

   function automatic void clear_parser();
      parse_phase = SEEK_HEADER;
      frame_offset = '0;
      unit_first = '0;
      unit_kind = '0;
      obu_size = '0;
      obu_size_bytes = 0;
      payload_left = '0;
   endfunction

   function automatic void post_locator_result(input logic [STATUS_W-1:0] status,
                                               input logic [63:0] start,
                                               input logic [63:0] length);
      result_type r;
      r.status = status;
      r.header_start = start[START_W-1:0];
      r.header_length = length[LEN_W-1:0];
      expected_results.push_back(r);
      parse_phase = SEEK_DONE;
   endfunction

   function automatic void close_obu();
      parse_phase = SEEK_HEADER;
      if (unit_kind == OBU_SEQUENCE_HEADER)
         post_locator_result(STATUS_FOUND, unit_first, frame_offset - unit_first);
   endfunction

   function automatic void track_frame_byte(input logic [7:0] b, input logic last);
      logic [63:0] here;
      logic [63:0] chunk;
      if (parse_phase != SEEK_DONE) begin
         if (frame_offset >= FRAME_BOUND) begin
            post_locator_result(STATUS_BAD, '0, '0);
         end else begin
            here = frame_offset;
            frame_offset = here + 1;
            case (parse_phase)
               SEEK_HEADER: begin
                  unit_first = here;
                  unit_kind = b[6:3];
                  if ((b & HDR_FORBIDDEN) != 0 || (b & HDR_RESERVED) != 0 ||
                      (b & HDR_HAS_SIZE) == 0) begin
                     post_locator_result(STATUS_BAD, '0, '0);
                  end else begin
                     obu_size = '0;
                     obu_size_bytes = 0;
                     parse_phase = ((b & HDR_EXT) != 0) ? SEEK_EXT : SEEK_SIZE;
                  end
               end
               SEEK_EXT: begin
                  parse_phase = SEEK_SIZE;
               end
               SEEK_SIZE: begin
                  chunk = 64'(b & LEB_VALUE) << (7 * (obu_size_bytes % LEB_MAX_BYTES));
                  obu_size = obu_size + chunk;
                  if (obu_size > FRAME_BOUND)
                     obu_size = FRAME_BOUND + 1;
                  obu_size_bytes++;
                  if ((b & LEB_MORE) != 0) begin
                     if (obu_size_bytes >= LEB_MAX_BYTES)
                        post_locator_result(STATUS_BAD, '0, '0);
                  end else if (obu_size > FRAME_BOUND - frame_offset) begin
                     post_locator_result(STATUS_BAD, '0, '0);
                  end else begin
                     payload_left = obu_size;
                     if (payload_left == 0)
                        close_obu();
                     else
                        parse_phase = SEEK_PAYLOAD;
                  end
               end
               default: begin
                  if (payload_left > 0)
                     payload_left--;
                  if (payload_left == 0)
                     close_obu();
               end
            endcase
         end
      end
      if (last) begin
         if (parse_phase != SEEK_DONE)
            post_locator_result((parse_phase == SEEK_HEADER) ? STATUS_NONE : STATUS_BAD,
                                '0, '0);
         clear_parser();
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      track_frame_byte(b, last);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic void push_obu_size(input logic [63:0] value);
      int nbytes;
      logic [7:0] b;
      nbytes = 1;
      while ((value >> (7 * nbytes)) != 0)
         nbytes++;
      if ($urandom_range(99) < 20)
         nbytes = $urandom_range(LEB_MAX_BYTES, nbytes);
      for (int i = 0; i < nbytes; i++) begin
         b = 8'(value >> (7 * i)) & LEB_VALUE;
         if (i < nbytes - 1)
            b = b | LEB_MORE;
         frame_buf.push_back(b);
      end
   endfunction

   function automatic void build_random_frame();
      int             n_units;
      int             flaw_unit;
      int             first_byte;
      int             cut;
      int             n_size;
      int unsigned    payload;
      frame_flaw_type flaw;
      logic [3:0]     kind;
      logic [7:0]     hdr;
      frame_buf.delete();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(12, 1))
            frame_buf.push_back(8'($urandom_range(255)));
         return;
      end
      n_units = $urandom_range(4, 1);
      flaw = ($urandom_range(99) < 30) ? frame_flaw_type'($urandom_range(6, 1)) : FLAW_NONE;
      flaw_unit = $urandom_range(n_units - 1);
      for (int u = 0; u < n_units; u++) begin
         kind = ($urandom_range(99) < 35) ? OBU_SEQUENCE_HEADER : 4'($urandom_range(15));
         hdr = obu_header(kind, 1'($urandom_range(1)));
         payload = ($urandom_range(99) < 4) ? $urandom_range(300, 128) : $urandom_range(12);
         first_byte = frame_buf.size();
         if (u == flaw_unit) begin
            case (flaw)
               FLAW_FORBIDDEN: hdr = hdr | HDR_FORBIDDEN;
               FLAW_RESERVED:  hdr = hdr | HDR_RESERVED;
               FLAW_NO_SIZE:   hdr = hdr & ~HDR_HAS_SIZE;
               default: ;
            endcase
         end
         frame_buf.push_back(hdr);
         if ((hdr & HDR_EXT) != 0)
            frame_buf.push_back(8'($urandom_range(255)));
         if (u == flaw_unit && flaw == FLAW_ENDLESS_SIZE) begin
            repeat (LEB_MAX_BYTES)
               frame_buf.push_back(LEB_MORE | 8'($urandom_range(127)));
         end else if (u == flaw_unit && flaw == FLAW_OVERSIZE) begin
            n_size = $urandom_range(LEB_MAX_BYTES, 4);
            repeat (n_size - 1)
               frame_buf.push_back(LEB_MORE | 8'($urandom_range(127)));
            frame_buf.push_back(8'((n_size == 4) ? $urandom_range(127, 8)
                                                  : $urandom_range(127, 1)));
         end else begin
            push_obu_size(64'(payload));
            repeat (payload)
               frame_buf.push_back(8'($urandom_range(255)));
         end
         if (u == flaw_unit && flaw == FLAW_TRUNCATED) begin
            cut = $urandom_range(frame_buf.size() - 1, first_byte + 1);
            while (frame_buf.size() > cut)
               void'(frame_buf.pop_back());
            return;
         end
      end
   endfunction

   task automatic test_directed_cases();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      frame_buf = {obu_header(OBU_SEQUENCE_HEADER, 1'b0), 8'h00};
      send_frame();
      frame_buf = {obu_header(OBU_TEMPORAL_DELIMITER, 1'b0) | HDR_FORBIDDEN, 8'hff};
      send_frame();
      frame_buf = {obu_header(OBU_TEMPORAL_DELIMITER, 1'b0) | HDR_RESERVED};
      send_frame();
      frame_buf = {obu_header(OBU_TEMPORAL_DELIMITER, 1'b0) & ~HDR_HAS_SIZE};
      send_frame();
      frame_buf = {obu_header(OBU_TEMPORAL_DELIMITER, 1'b0), 8'h00};
      send_frame();
      frame_buf = {obu_header(OBU_TEMPORAL_DELIMITER, 1'b0), 8'h00,
                   obu_header(OBU_SEQUENCE_HEADER, 1'b1), 8'h00,
                   LEB_MORE | 8'h01, 8'h00, 8'hff};
      send_frame();
      frame_buf = {obu_header(OBU_PADDING, 1'b0)};
      repeat (LEB_MAX_BYTES)
         frame_buf.push_back(LEB_MORE | LEB_VALUE);
      send_frame();
      frame_buf = {obu_header(OBU_SEQUENCE_HEADER, 1'b0), LEB_MORE, LEB_MORE, LEB_MORE, 8'h08};
      send_frame();
      frame_buf = {obu_header(OBU_SEQUENCE_HEADER, 1'b0), 8'h05, 8'haa};
      send_frame();
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_bytes);
      int sent;
      sent = 0;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (sent < n_bytes) begin
         build_random_frame();
         send_frame();
         sent += frame_buf.size();
      end
      wait_for_results();
   endtask

   // Every frame here decides at once, so the output register fills while
   // the receiver is held off and the input side has to stall.
   task automatic test_output_backpressure();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      holds_requested++;
      for (int i = 0; i < 48; i++) begin
         if (i % 2 == 0)
            frame_buf = {obu_header(OBU_SEQUENCE_HEADER, 1'b0), 8'h00};
         else
            frame_buf = {obu_header(4'($urandom_range(15)), 1'b0) | HDR_FORBIDDEN};
         send_frame();
      end
      wait_for_results();
   endtask

   always @(posedge clock) begin : rsp_sink
      int hold_left;
      int holds_served;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         holds_served = holds_requested;
      end else if (holds_served != holds_requested) begin
         holds_served++;
         hold_left = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.status = rsp_tuser[STATUS_W-1:0];
         seen.header_start = rsp_tdata[START_W-1:0];
         seen.header_length = rsp_tdata[START_W +: LEN_W];
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction: status %0d start %0d length %0d",
                   seen.status, seen.header_start, seen.header_length);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (seen.status != want.status) begin
               $error("status: expected %0d, actual %0d", want.status, seen.status);
               error_count++;
            end
            if (seen.header_start != want.header_start) begin
               $error("header_start: expected %0d, actual %0d",
                      want.header_start, seen.header_start);
               error_count++;
            end
            if (seen.header_length != want.header_length) begin
               $error("header_length: expected %0d, actual %0d",
                      want.header_length, seen.header_length);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      clear_parser();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_traffic(0, 0, 400);
      test_random_traffic(70, 0, 400);
      test_random_traffic(0, 70, 400);
      test_random_traffic(21, 21, 400);
      test_output_backpressure();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
rtl/av1shl_pkg.sv
rtl/av1shl_parser.sv
rtl/av1_sequence_header_locator_core.sv
tb/tb_av1_sequence_header_locator_core.sv
